// ===== hdl/wildcard_glob_matcher_assert.svh =====
// Assertion macros used by the glob matcher port checker.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Same-cycle implication, clocked on clk, masked while arst_n is low.
`define WGM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glob matcher check failed");

// Next-cycle implication, clocked on clk, masked while arst_n is low.
`define WGM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glob matcher check failed");

`endif

// ===== hdl/wgm_pkg.sv =====
// Types and constants of the glob matcher.
`default_nettype none

package wgm_pkg;

	localparam logic [7:0] SYM_STAR = 8'h2A;
	localparam logic [7:0] SYM_ANY  = 8'h3F;

	typedef logic [1:0] op_t;
	localparam op_t OP_PATTERN = 2'd0;
	localparam op_t OP_SUBJECT = 2'd1;
	localparam op_t OP_END     = 2'd2;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic       start;    // pattern or end beat: only position zero live
		logic       step;     // subject byte advances the live set
		logic       restart;  // drop the stored pattern
		logic       store;    // pattern byte goes into the selected cell
		logic [7:0] symbol;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/wgm_cell.sv =====
// One pattern position: stored byte, occupancy and live bit.
`default_nettype none

module wgm_cell
	import wgm_pkg::*;
#(
	parameter bit HEAD = 1'b0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      wr_sel,
	input  wire logic      hint_in,
	input  wire logic      fwd_in,
	output logic           hint_out,
	output logic           fwd_out,
	output logic           closed
);

	logic [7:0] byte_q;
	logic       occ_q;
	logic       live_q;
	logic       is_star;
	logic       hit;

	// a star never follows a star in the store, so closure is one hop
	assign closed   = live_q | hint_in;
	assign is_star  = occ_q & (byte_q == SYM_STAR);
	assign hit      = (byte_q == SYM_ANY) | (byte_q == ctl.symbol);
	assign hint_out = live_q & is_star;
	assign fwd_out  = closed & occ_q & !is_star & hit;

	always_ff @(posedge clk) begin
		if (ctl.store && wr_sel) begin
			byte_q <= ctl.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			live_q <= HEAD;
		end else begin
			if (ctl.store && wr_sel) begin
				occ_q <= 1'b1;
			end else if (ctl.restart) begin
				occ_q <= 1'b0;
			end
			if (ctl.start) begin
				live_q <= HEAD;
			end else if (ctl.step) begin
				live_q <= fwd_in | (closed & is_star);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wildcard_glob_matcher.sv =====
// Glob matcher top level: append logic, cell chain and result register.
//
// Channels: one input channel (in_valid / in_stall, fields operation, symbol,
// restart) and one result channel (out_valid / out_stall, fields matched,
// overflow). A beat moves at a rising edge with valid high and stall low.
// Operation 0 appends a pattern byte (restart clears the pattern first),
// operation 1 feeds a subject byte, operation 2 ends the subject and yields
// one result beat; operation 3 is a no-op.
// Throughput: one input beat per cycle unless stalled. Each cell of the chain
// owns one pattern position and updates its live bit from its left neighbour
// in the same cycle, so the live set advances once per subject beat.
// Latency: a result appears on out_valid the cycle after its end beat.
// Runs of stars are kept as one star in the cells while the logical length
// still counts every byte, so capacity overflow follows the byte count.
// Reset: empty pattern, overflow clear, only position zero live; no result.
// Stall: a waiting result holds its payload; pattern and subject beats are
// still taken, and only an end beat is held off until the result is taken.
`default_nettype none

module wildcard_glob_matcher
	import wgm_pkg::*;
#(
	parameter int PATTERN_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] symbol,
	input  wire logic       restart,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            matched,
	output logic            overflow
);

	localparam int LW = $clog2(PATTERN_DEPTH + 1);

	logic [LW-1:0] cnt_q;        // logical pattern length
	logic [LW-1:0] plen_q;       // bytes held in cells
	logic          last_star_q;  // last stored byte was a star
	logic          ovf_q;
	logic          live_tail_q;  // position just past the last cell

	logic          out_valid_q;
	logic          matched_q;
	logic          overflow_q;

	logic          accept;
	logic          is_pat;
	logic          is_sub;
	logic          is_end;
	logic [LW-1:0] base_cnt;
	logic [LW-1:0] base_plen;
	logic          base_last;
	logic          base_ovf;
	logic          full;
	logic          sym_star;
	logic          keep_byte;
	cell_ctl_t     ctl;

	logic [PATTERN_DEPTH:0] fwd_v;
	logic [PATTERN_DEPTH:0] hint_v;
	logic [PATTERN_DEPTH:0] closed_v;

	assign is_pat = (operation == OP_PATTERN);
	assign is_sub = (operation == OP_SUBJECT);
	assign is_end = (operation == OP_END);

	// only an end beat needs the result register
	assign in_stall = out_valid_q & out_stall & is_end;
	assign accept   = in_valid & !in_stall;

	// restart empties the pattern before this byte lands
	assign base_cnt  = restart ? '0 : cnt_q;
	assign base_plen = restart ? '0 : plen_q;
	assign base_last = restart ? 1'b0 : last_star_q;
	assign base_ovf  = restart ? 1'b0 : ovf_q;
	assign full      = (base_cnt == LW'(PATTERN_DEPTH));
	assign sym_star  = (symbol == SYM_STAR);
	// a star straight after a star adds nothing to the match set
	assign keep_byte = !full & !(sym_star & base_last);

	assign ctl.start   = accept & (is_pat | is_end);
	assign ctl.step    = accept & is_sub;
	assign ctl.restart = accept & is_pat & restart;
	assign ctl.store   = accept & is_pat & keep_byte;
	assign ctl.symbol  = symbol;

	assign fwd_v[0]  = 1'b0;
	assign hint_v[0] = 1'b0;

	for (genvar i = 0; i < PATTERN_DEPTH; i++) begin : g_cell
		wgm_cell #(
			.HEAD (i == 0)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_sel   (base_plen == LW'(i)),
			.hint_in  (hint_v[i]),
			.fwd_in   (fwd_v[i]),
			.hint_out (hint_v[i+1]),
			.fwd_out  (fwd_v[i+1]),
			.closed   (closed_v[i])
		);
	end

	// the tail position has no byte of its own, it only collects
	assign closed_v[PATTERN_DEPTH] = live_tail_q | hint_v[PATTERN_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			plen_q      <= '0;
			last_star_q <= 1'b0;
			ovf_q       <= 1'b0;
			live_tail_q <= 1'b0;
		end else begin
			if (accept && is_pat) begin
				if (full) begin
					cnt_q       <= base_cnt;
					plen_q      <= base_plen;
					last_star_q <= base_last;
					ovf_q       <= 1'b1;
				end else begin
					cnt_q       <= base_cnt + LW'(1);
					plen_q      <= keep_byte ? base_plen + LW'(1) : base_plen;
					last_star_q <= sym_star;
					ovf_q       <= base_ovf;
				end
			end
			if (ctl.start) begin
				live_tail_q <= 1'b0;
			end else if (ctl.step) begin
				live_tail_q <= fwd_v[PATTERN_DEPTH];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_end) begin
			matched_q  <= closed_v[plen_q] & !ovf_q;
			overflow_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

endmodule

`default_nettype wire

// ===== hdl/wgm_checker.sv =====
// Port-level checks of the glob matcher, bound to the top level.
`default_nettype none
`include "wildcard_glob_matcher_assert.svh"

module wgm_port_checks
	import wgm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] operation,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       matched,
	input wire logic       overflow
);

	// overflow forces a miss
	`WGM_ASSERT_NOW(a_ovf_no_match, out_valid && overflow, !matched)
	// an accepted end beat always shows a result next cycle
	`WGM_ASSERT_NEXT(a_end_gives_result, in_valid && !in_stall && operation == OP_END, out_valid)
	// input is held off only behind a stalled result
	`WGM_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
	// stalled result keeps its payload
	`WGM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(matched) && $stable(overflow))

endmodule

bind wildcard_glob_matcher wgm_port_checks u_wgm_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operation (operation),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.matched   (matched),
	.overflow  (overflow)
);

`default_nettype wire
